### rtl/core/frr_pkg.sv
// Shared types and constants for the framed result receiver.
package frr_pkg;

	typedef enum logic [2:0] {
		KIND_CONSOLE = 3'd0,
		KIND_PAYLOAD = 3'd1,
		KIND_ACK     = 3'd2,
		KIND_DONE    = 3'd3,
		KIND_TIMEOUT = 3'd4
	} kind_t;

	typedef enum logic {
		OP_BYTE = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic {
		REG_CHUNK_SIZE   = 1'b0,
		REG_BYTE_TIMEOUT = 1'b1
	} reg_index_t;

	localparam logic [7:0] HDR_NORMAL    = 8'h01;
	localparam logic [7:0] HDR_EXCEPTION = 8'h02;
	localparam logic [7:0] ACK_FIRST     = 8'h21;
	localparam logic [7:0] ACK_CHUNK     = 8'h23;

	localparam logic [7:0] CHUNK_SIZE_RST   = 8'd100;
	localparam logic [7:0] BYTE_TIMEOUT_RST = 8'd20;

	// Most results one item can cause
	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] data;
		logic       exc;
		logic       last;
	} result_t;

endpackage

### rtl/core/framed_result_receiver.sv
// Framed result receiver: header hunt, length, payload pass-through and acknowledges.
//
// Each accepted item (a received byte or one timer tick) is decoded in the cycle it is
// accepted: the frame state updates at once and the zero to three results it causes are
// written into a four-entry result queue that drives the output stream, one result per
// cycle while m_tready is high. A steady stream of items that each cause a single result
// runs at one item per clock while the output is ready. Input ready is high while at most
// one result is queued; an item causing two or three results (ack plus frame done, payload
// plus chunk ack plus frame done) therefore holds the output for each of its results, and
// the input stalls until the queue has drained back to one entry. Configuration writes
// must only be made while no results are pending.
module framed_result_receiver (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] rx_byte
	input  logic [0:0]  s_tuser,   // [0] op
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] data, [8] exc, [15:9] zero
	output logic [2:0]  m_tuser,   // [2:0] kind
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	typedef enum logic [1:0] {
		PH_HUNT     = 2'd0,
		PH_LEN_HIGH = 2'd1,
		PH_LEN_LOW  = 2'd2,
		PH_PAYLOAD  = 2'd3
	} phase_t;

	localparam int unsigned QDEPTH = 4;

	// configuration
	logic [7:0] chunk_size_q;
	logic [7:0] byte_timeout_q;

	// frame state
	phase_t      phase_q,      phase_d;
	logic        exc_q,        exc_d;
	logic [7:0]  len_high_q,   len_high_d;
	logic [15:0] remaining_q,  remaining_d;
	logic [7:0]  chunk_cnt_q,  chunk_cnt_d;
	logic [7:0]  idle_q,       idle_d;

	// result queue
	frr_pkg::result_t queue_q [QDEPTH];
	logic [1:0] wr_ptr_q;
	logic [1:0] rd_ptr_q;
	logic [2:0] count_q;

	frr_pkg::result_t res [frr_pkg::MAX_RES];
	logic [1:0]  nres;
	logic        accept;
	logic        pop;
	logic [8:0]  tick_sum;
	logic [15:0] rem_dec;
	logic [7:0]  cnt_inc;
	logic        chunk_ack;
	logic [7:0]  rx_byte;

	assign rx_byte  = s_tdata;
	assign s_tready = (count_q <= 3'd1);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = (count_q != 3'd0);
	assign pop      = m_tvalid && m_tready;

	assign tick_sum  = {1'b0, idle_q} + 9'd1;
	assign rem_dec   = remaining_q - 16'd1;
	assign cnt_inc   = chunk_cnt_q + 8'd1;
	assign chunk_ack = (cnt_inc == chunk_size_q) || (rem_dec == 16'd0);

	always_comb begin
		phase_d     = phase_q;
		exc_d       = exc_q;
		len_high_d  = len_high_q;
		remaining_d = remaining_q;
		chunk_cnt_d = chunk_cnt_q;
		idle_d      = idle_q;
		nres        = 2'd0;
		for (int i = 0; i < frr_pkg::MAX_RES; i++) begin
			res[i] = '{kind: frr_pkg::KIND_CONSOLE, data: 8'h00, exc: exc_q, last: 1'b0};
		end

		if (s_tuser[0] == frr_pkg::OP_TICK) begin
			if (phase_q != PH_HUNT) begin
				if (tick_sum >= {1'b0, byte_timeout_q}) begin
					res[0].kind = frr_pkg::KIND_TIMEOUT;
					nres        = 2'd1;
					phase_d     = PH_HUNT;
					exc_d       = 1'b0;
					len_high_d  = 8'h00;
					remaining_d = 16'h0000;
					chunk_cnt_d = 8'h00;
					idle_d      = 8'h00;
				end else begin
					idle_d = tick_sum[7:0];
				end
			end
		end else begin
			idle_d = 8'h00;
			case (phase_q)
				PH_HUNT: begin
					if (rx_byte == frr_pkg::HDR_NORMAL || rx_byte == frr_pkg::HDR_EXCEPTION) begin
						exc_d   = (rx_byte == frr_pkg::HDR_EXCEPTION);
						phase_d = PH_LEN_HIGH;
					end else begin
						res[0].kind = frr_pkg::KIND_CONSOLE;
						res[0].data = rx_byte;
						res[0].exc  = 1'b0;
						nres        = 2'd1;
					end
				end
				PH_LEN_HIGH: begin
					len_high_d = rx_byte;
					phase_d    = PH_LEN_LOW;
				end
				PH_LEN_LOW: begin
					res[0].kind = frr_pkg::KIND_ACK;
					res[0].data = frr_pkg::ACK_FIRST;
					chunk_cnt_d = 8'h00;
					if ({len_high_q, rx_byte} == 16'h0000) begin
						res[1].kind = frr_pkg::KIND_DONE;
						nres        = 2'd2;
						phase_d     = PH_HUNT;
						exc_d       = 1'b0;
						len_high_d  = 8'h00;
						remaining_d = 16'h0000;
					end else begin
						nres        = 2'd1;
						remaining_d = {len_high_q, rx_byte};
						phase_d     = PH_PAYLOAD;
					end
				end
				PH_PAYLOAD: begin
					res[0].kind = frr_pkg::KIND_PAYLOAD;
					res[0].data = rx_byte;
					remaining_d = rem_dec;
					chunk_cnt_d = cnt_inc;
					nres        = 2'd1;
					if (chunk_ack) begin
						res[1].kind = frr_pkg::KIND_ACK;
						res[1].data = frr_pkg::ACK_CHUNK;
						chunk_cnt_d = 8'h00;
						nres        = 2'd2;
					end
					// final byte always comes with a chunk ack, so done sits in slot 2
					if (rem_dec == 16'd0) begin
						res[2].kind = frr_pkg::KIND_DONE;
						nres        = 2'd3;
						phase_d     = PH_HUNT;
						exc_d       = 1'b0;
						len_high_d  = 8'h00;
						remaining_d = 16'h0000;
						chunk_cnt_d = 8'h00;
					end
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end

		case (nres)
			2'd1:    res[0].last = 1'b1;
			2'd2:    res[1].last = 1'b1;
			2'd3:    res[2].last = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_size_q   <= frr_pkg::CHUNK_SIZE_RST;
			byte_timeout_q <= frr_pkg::BYTE_TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				frr_pkg::REG_CHUNK_SIZE:   chunk_size_q   <= cfg_data;
				frr_pkg::REG_BYTE_TIMEOUT: byte_timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HUNT;
			exc_q       <= 1'b0;
			len_high_q  <= 8'h00;
			remaining_q <= 16'h0000;
			chunk_cnt_q <= 8'h00;
			idle_q      <= 8'h00;
		end else if (accept) begin
			phase_q     <= phase_d;
			exc_q       <= exc_d;
			len_high_q  <= len_high_d;
			remaining_q <= remaining_d;
			chunk_cnt_q <= chunk_cnt_d;
			idle_q      <= idle_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 2'd0;
			rd_ptr_q <= 2'd0;
			count_q  <= 3'd0;
		end else begin
			if (accept) begin
				wr_ptr_q <= wr_ptr_q + nres;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 2'd1;
			end
			count_q <= count_q + (accept ? {1'b0, nres} : 3'd0) - {2'b00, pop};
		end
	end

	// queue payload, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int i = 0; i < frr_pkg::MAX_RES; i++) begin
				if (2'(i) < nres) begin
					queue_q[wr_ptr_q + 2'(i)] <= res[i];
				end
			end
		end
	end

	assign m_tdata = {7'b0000000, queue_q[rd_ptr_q].exc, queue_q[rd_ptr_q].data};
	assign m_tuser = queue_q[rd_ptr_q].kind;
	assign m_tlast = queue_q[rd_ptr_q].last;

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= 3'(QDEPTH))
		else $error("result queue overflow");

	a_accept_room: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> count_q <= 3'd1)
		else $error("item accepted without room for its results");

	a_hunt_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_HUNT |-> (!exc_q && idle_q == 8'h00))
		else $error("stale frame state while hunting");

	a_payload_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> remaining_q != 16'h0000)
		else $error("payload phase with nothing remaining");

	a_multi_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && nres == 2'd3) |=> !s_tready)
		else $error("input not held off after a three-result item");

endmodule
